@@ design/pbsa_pkg.sv @@
package pbsa_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_INVALID     = 2'd3
    } status_t;

    localparam int PAGE_FIELD_W = 4;
    localparam int SLOT_FIELD_W = 5;

endpackage

@@ design/paged_bitmap_slot_allocator_top.sv @@
// Allocate steps over full pages from the page hint; an absent page is brought in at slot 0,
// else the slot search starts at the slot hint and wraps to slot 0 when nothing above is free;
// with no free slot in any page the result is a no-space status.
// Free checks the release candidate when the page empties.
// One request is in work at a time; the next is taken in the cycle after the result register loads.
// Synchronous active-low reset clears all use bits, hints, presence flags and the candidate.
module paged_bitmap_slot_allocator_top #(
    parameter int PAGE_COUNT    = 16,
    parameter int LOG_MAX_SLOTS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [pbsa_pkg::PAGE_FIELD_W-1:0]   s_page_index,
    input  logic [pbsa_pkg::SLOT_FIELD_W-1:0]   s_slot_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pbsa_pkg::status_t                   m_status,
    output logic [pbsa_pkg::PAGE_FIELD_W-1:0]   m_granted_page,
    output logic [pbsa_pkg::SLOT_FIELD_W-1:0]   m_granted_slot,
    output logic                                m_page_brought_in,
    output logic                                m_page_released,
    output logic [pbsa_pkg::PAGE_FIELD_W-1:0]   m_released_page
);
    import pbsa_pkg::*;

    localparam int SW   = LOG_MAX_SLOTS;
    localparam int CW   = SW + 1;
    localparam int MAXS = 1 << SW;
    localparam int PW   = $clog2(PAGE_COUNT);
    localparam int HW   = $clog2(PAGE_COUNT + 1);

    typedef enum logic [2:0] {
        IDLE, SCAN, SLOT_HINT, SLOT_WRAP, ACOMMIT, FCHECK, FRELEASE, DONE
    } state_t;

    function automatic logic [CW-1:0] cnt_of(input logic [PW-1:0] p);
        cnt_of = (32'(p) < LOG_MAX_SLOTS) ? CW'(1 << p) : CW'(MAXS);
    endfunction

    state_t state_reg;

    logic [MAXS-1:0] use_reg [PAGE_COUNT];
    logic [CW-1:0]   hint_reg [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] present_reg;
    logic [HW-1:0]   page_hint_reg;
    logic [PW-1:0]   cand_reg;

    logic [PAGE_FIELD_W-1:0] pidx_reg;
    logic [SLOT_FIELD_W-1:0] sidx_reg;
    logic [HW-1:0]           cur_reg;
    logic [SW-1:0]           slot_reg;

    status_t                 res_status_reg;
    logic [PAGE_FIELD_W-1:0] res_gpage_reg;
    logic [SLOT_FIELD_W-1:0] res_gslot_reg;
    logic                    res_brought_reg;
    logic                    res_released_reg;
    logic [PAGE_FIELD_W-1:0] res_rpage_reg;

    logic                    m_valid_reg;
    status_t                 m_status_reg;
    logic [PAGE_FIELD_W-1:0] m_gpage_reg;
    logic [SLOT_FIELD_W-1:0] m_gslot_reg;
    logic                    m_brought_reg;
    logic                    m_released_reg;
    logic [PAGE_FIELD_W-1:0] m_rpage_reg;

    logic            cur_in_range;
    logic            page_ok;
    logic [PW-1:0]   fpage;
    logic [SW-1:0]   fslot;
    logic [PW-1:0]   rd_page;
    logic [MAXS-1:0] rd_word;
    logic [CW-1:0]   rd_cnt;
    logic [CW-1:0]   ffz_lo;
    logic            ffz_found;
    logic [SW-1:0]   ffz_idx;
    logic            free_ok;
    logic [MAXS-1:0] freed_word;
    logic [PW-1:0]   rel_hi;
    logic [PW-1:0]   rel_lo;

    assign cur_in_range = 32'(cur_reg) < PAGE_COUNT;
    assign page_ok      = 32'(pidx_reg) < PAGE_COUNT;
    assign fpage        = page_ok ? PW'(pidx_reg) : '0;
    assign fslot        = SW'(sidx_reg);

    always_comb begin
        unique case (state_reg)
            SCAN, SLOT_HINT, SLOT_WRAP, ACOMMIT: rd_page = cur_in_range ? PW'(cur_reg) : '0;
            FCHECK:                              rd_page = fpage;
            FRELEASE:                            rd_page = cand_reg;
            default:                             rd_page = '0;
        endcase
    end

    assign rd_word = use_reg[rd_page];
    assign rd_cnt  = cnt_of(rd_page);
    assign ffz_lo  = (state_reg == SLOT_HINT) ? hint_reg[rd_page] : '0;

    pbsa_ffz #(
        .IDX_W (SW)
    ) u_ffz (
        .word  (rd_word),
        .lo    (ffz_lo),
        .cnt   (rd_cnt),
        .found (ffz_found),
        .idx   (ffz_idx)
    );

    assign free_ok    = page_ok && (32'(sidx_reg) < 32'(rd_cnt)) && present_reg[fpage];
    assign freed_word = rd_word & ~(MAXS'(1) << fslot);
    assign rel_hi     = (cand_reg > fpage) ? cand_reg : fpage;
    assign rel_lo     = (cand_reg < fpage) ? cand_reg : fpage;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            m_valid_reg   <= 1'b0;
            present_reg   <= '0;
            page_hint_reg <= '0;
            cand_reg      <= '0;
            for (int i = 0; i < PAGE_COUNT; i++) begin
                use_reg[i]  <= '0;
                hint_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        pidx_reg         <= s_page_index;
                        sidx_reg         <= s_slot_index;
                        cur_reg          <= page_hint_reg;
                        res_status_reg   <= ST_OK;
                        res_gpage_reg    <= '0;
                        res_gslot_reg    <= '0;
                        res_brought_reg  <= 1'b0;
                        res_released_reg <= 1'b0;
                        res_rpage_reg    <= '0;
                        state_reg        <= s_mode ? FCHECK : SCAN;
                    end
                end
                SCAN: begin
                    if (!cur_in_range) begin
                        res_status_reg <= ST_NO_SPACE;
                        state_reg      <= DONE;
                    end else if (!ffz_found) begin
                        cur_reg <= HW'(cur_reg + 1'b1);
                    end else if (!present_reg[rd_page]) begin
                        slot_reg        <= '0;
                        res_brought_reg <= 1'b1;
                        state_reg       <= ACOMMIT;
                    end else begin
                        state_reg <= SLOT_HINT;
                    end
                end
                SLOT_HINT: begin
                    slot_reg  <= ffz_idx;
                    state_reg <= ffz_found ? ACOMMIT : SLOT_WRAP;
                end
                SLOT_WRAP: begin
                    slot_reg  <= ffz_idx;
                    state_reg <= ACOMMIT;
                end
                ACOMMIT: begin
                    if (res_brought_reg) begin
                        use_reg[rd_page] <= MAXS'(1) << slot_reg;
                    end else begin
                        use_reg[rd_page][slot_reg] <= 1'b1;
                    end
                    present_reg[rd_page] <= 1'b1;
                    if (CW'(CW'(slot_reg) + 1'b1) == rd_cnt) begin
                        page_hint_reg     <= HW'(cur_reg + 1'b1);
                        hint_reg[rd_page] <= CW'(rd_cnt + 1'b1);
                    end else begin
                        page_hint_reg     <= cur_reg;
                        hint_reg[rd_page] <= CW'(CW'(slot_reg) + 1'b1);
                    end
                    res_gpage_reg <= PAGE_FIELD_W'(rd_page);
                    res_gslot_reg <= SLOT_FIELD_W'(slot_reg);
                    state_reg     <= DONE;
                end
                FCHECK: begin
                    if (!free_ok) begin
                        res_status_reg <= ST_INVALID;
                        state_reg      <= DONE;
                    end else if (!rd_word[fslot]) begin
                        res_status_reg <= ST_DOUBLE_FREE;
                        state_reg      <= DONE;
                    end else begin
                        use_reg[fpage] <= freed_word;
                        if (hint_reg[fpage] > CW'(fslot)) begin
                            hint_reg[fpage] <= CW'(fslot);
                        end
                        if (page_hint_reg > HW'(fpage)) begin
                            page_hint_reg <= HW'(fpage);
                        end
                        state_reg <= (freed_word == '0) ? FRELEASE : DONE;
                    end
                end
                FRELEASE: begin
                    if ((rd_word == '0) && present_reg[cand_reg]) begin
                        present_reg[rel_hi] <= 1'b0;
                        cand_reg            <= rel_lo;
                        res_released_reg    <= 1'b1;
                        res_rpage_reg       <= PAGE_FIELD_W'(rel_hi);
                    end else begin
                        cand_reg <= fpage;
                    end
                    state_reg <= DONE;
                end
                DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= res_status_reg;
                        m_gpage_reg    <= res_gpage_reg;
                        m_gslot_reg    <= res_gslot_reg;
                        m_brought_reg  <= res_brought_reg;
                        m_released_reg <= res_released_reg;
                        m_rpage_reg    <= res_rpage_reg;
                        state_reg      <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready           = (state_reg == IDLE);
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_page    = m_gpage_reg;
    assign m_granted_slot    = m_gslot_reg;
    assign m_page_brought_in = m_brought_reg;
    assign m_page_released   = m_released_reg;
    assign m_released_page   = m_rpage_reg;

    // The page hint never points past one beyond the last page.
    a_page_hint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(page_hint_reg) <= PAGE_COUNT)
        else $error("page hint out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a request is in work");

    a_release_excludes_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_page_released) |->
            (m_granted_page == '0 && m_granted_slot == '0 && !m_page_brought_in
             && m_status == ST_OK))
        else $error("release reported together with a grant");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
            (!m_page_released && !m_page_brought_in && m_granted_slot == '0
             && m_granted_page == '0 && m_released_page == '0))
        else $error("failed request carries nonzero fields");

endmodule

@@ design/pbsa_ffz.sv @@
module pbsa_ffz #(
    parameter int IDX_W = 5
) (
    input  logic [(1 << IDX_W)-1:0] word,
    input  logic [IDX_W:0]          lo,
    input  logic [IDX_W:0]          cnt,
    output logic                    found,
    output logic [IDX_W-1:0]        idx
);

    localparam int WIDTH = 1 << IDX_W;
    localparam int CW    = IDX_W + 1;

    logic [WIDTH-1:0] elig;

    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            elig[i] = !word[i] && (CW'(i) >= lo) && (CW'(i) < cnt);
        end
    end

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (elig[i]) begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pbsa_pkg::*;

    localparam int  PAGE_COUNT    = 16;
    localparam int  LOG_MAX_SLOTS = 5;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  REPORT_LIMIT  = 10;
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_FREE    = 1'b1;

    typedef struct packed {
        status_t    status;
        logic [3:0] page;
        logic [4:0] slot;
        logic       brought_in;
        logic       released;
        logic [3:0] released_page;
    } slot_result_t;

    typedef struct packed {
        logic         mode;
        logic [3:0]   page;
        logic [4:0]   slot;
        logic         known;
        slot_result_t result;
    } request_row_t;

    localparam int OPENING_ROWS = 22;

    // Walks the special cases from reset: invalid and double frees, the release of the emptied
    // page itself, an absent candidate, a busy candidate and the higher of two empty pages.
    request_row_t opening_rows [OPENING_ROWS] = '{
        '{MODE_FREE,  4'd0,  5'd0,  1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b1, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd1, 5'd0, 1'b1, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd1, 5'd1, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd1,  5'd1,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd1,  5'd1,  1'b1, '{ST_DOUBLE_FREE, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd1,  5'd2,  1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd15, 5'd31, 1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd0,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b1, 4'd0}},
        '{MODE_FREE,  4'd1,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd15, 5'd31, 1'b1, '{ST_OK,          4'd0, 5'd0, 1'b1, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd1, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd0,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd1,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b1, 4'd1}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd0,  5'd0,  1'b1, '{ST_OK,          4'd1, 5'd0, 1'b1, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd15, 5'd31, 1'b0, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_ALLOC, 4'd7,  5'd10, 1'b0, '{ST_OK,          4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd2,  5'd3,  1'b1, '{ST_DOUBLE_FREE, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd2,  5'd4,  1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd0,  5'd31, 1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}},
        '{MODE_FREE,  4'd14, 5'd0,  1'b1, '{ST_INVALID,     4'd0, 5'd0, 1'b0, 1'b0, 4'd0}}
    };

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic       s_mode       = MODE_ALLOC;
    logic [3:0] s_page_index = '0;
    logic [4:0] s_slot_index = '0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    status_t    m_status;
    logic [3:0] m_granted_page;
    logic [4:0] m_granted_slot;
    logic       m_page_brought_in;
    logic       m_page_released;
    logic [3:0] m_released_page;

    logic [31:0] slot_used [PAGE_COUNT];
    logic [5:0]  next_slot [PAGE_COUNT];
    logic        page_live [PAGE_COUNT];
    int          next_page;
    int          spare_page;

    slot_result_t pending_results [$];
    slot_result_t observed;
    slot_result_t wanted;
    int           mismatch_count    = 0;
    int           cycle_count       = 0;
    int           sender_idle_pct   = 0;
    int           receiver_idle_pct = 0;

    paged_bitmap_slot_allocator_top #(
        .PAGE_COUNT   (PAGE_COUNT),
        .LOG_MAX_SLOTS(LOG_MAX_SLOTS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_page_index     (s_page_index),
        .s_slot_index     (s_slot_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_page   (m_granted_page),
        .m_granted_slot   (m_granted_slot),
        .m_page_brought_in(m_page_brought_in),
        .m_page_released  (m_page_released),
        .m_released_page  (m_released_page)
    );

    always #10 aclk = ~aclk;

    function automatic int page_capacity(int p);
        return 1 << ((p < LOG_MAX_SLOTS) ? p : LOG_MAX_SLOTS);
    endfunction

    function automatic slot_result_t predict_allocator(logic mode, logic [3:0] page,
                                                       logic [4:0] slot);
        slot_result_t r;
        int p;
        int cap;
        int s;
        logic found;
        int hi;
        int lo;
        r = '{ST_OK, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0};
        if (mode == MODE_ALLOC) begin
            p = next_page;
            while (p < PAGE_COUNT) begin
                cap = page_capacity(p);
                if (slot_used[p] != 32'((64'd1 << cap) - 64'd1)) break;
                p++;
            end
            if (p >= PAGE_COUNT) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            cap = page_capacity(p);
            s = 0;
            found = 1'b0;
            if (!page_live[p]) begin
                page_live[p] = 1'b1;
                slot_used[p] = '0;
                r.brought_in = 1'b1;
            end else begin
                for (int i = int'(next_slot[p]); i < cap; i++) begin
                    if (!found && !slot_used[p][i]) begin
                        s = i;
                        found = 1'b1;
                    end
                end
                for (int i = 0; i < cap; i++) begin
                    if (!found && !slot_used[p][i]) begin
                        s = i;
                        found = 1'b1;
                    end
                end
            end
            slot_used[p][s] = 1'b1;
            if (s + 1 == cap) begin
                next_page = p + 1;
                next_slot[p] = 6'(cap + 1);
            end else begin
                next_page = p;
                next_slot[p] = 6'(s + 1);
            end
            r.page = 4'(p);
            r.slot = 5'(s);
            return r;
        end
        p = int'(page);
        s = int'(slot);
        if (s >= page_capacity(p) || !page_live[p]) begin
            r.status = ST_INVALID;
            return r;
        end
        if (!slot_used[p][s]) begin
            r.status = ST_DOUBLE_FREE;
            return r;
        end
        slot_used[p][s] = 1'b0;
        if (int'(next_slot[p]) > s) next_slot[p] = 6'(s);
        if (next_page > p) next_page = p;
        if (slot_used[p] == '0) begin
            if (slot_used[spare_page] == '0 && page_live[spare_page]) begin
                hi = (spare_page > p) ? spare_page : p;
                lo = (spare_page < p) ? spare_page : p;
                page_live[hi] = 1'b0;
                spare_page = lo;
                r.released = 1'b1;
                r.released_page = 4'(hi);
            end else begin
                spare_page = p;
            end
        end
        return r;
    endfunction

    function automatic string result_text(slot_result_t r);
        return $sformatf("status %s page %0d slot %0d brought_in %0b released %0b/%0d",
                         r.status.name(), r.page, r.slot, r.brought_in, r.released,
                         r.released_page);
    endfunction

    task automatic send_request(logic mode, logic [3:0] page, logic [4:0] slot, logic known,
                                slot_result_t known_result);
        slot_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        predicted = predict_allocator(mode, page, slot);
        pending_results.push_back(known ? known_result : predicted);
        s_valid      = 1'b1;
        s_mode       = mode;
        s_page_index = page;
        s_slot_index = slot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_requests(int count, int alloc_pct);
        int busy_pages [$];
        int used_slots [$];
        int pick;
        int p;
        int roll;
        logic [3:0] page;
        logic [4:0] slot;
        for (int n = 0; n < count; n++) begin
            busy_pages.delete();
            used_slots.delete();
            for (int i = 0; i < PAGE_COUNT; i++) if (slot_used[i] != '0) busy_pages.push_back(i);
            page = 4'($urandom_range(15));
            slot = 5'($urandom_range(31));
            roll = $urandom_range(99);
            if ($urandom_range(99) < alloc_pct) begin
                send_request(MODE_ALLOC, page, slot, 1'b0, '0);
            end else if (roll < 80 && busy_pages.size() != 0) begin
                pick = $urandom_range(busy_pages.size() - 1);
                p = busy_pages[pick];
                for (int i = 0; i < 32; i++) if (slot_used[p][i]) used_slots.push_back(i);
                pick = $urandom_range(used_slots.size() - 1);
                send_request(MODE_FREE, 4'(p), 5'(used_slots[pick]), 1'b0, '0);
            end else if (roll < 90) begin
                p = int'(page);
                send_request(MODE_FREE, page, 5'($urandom_range(page_capacity(p) - 1)), 1'b0,
                             '0);
            end else begin
                send_request(MODE_FREE, page, slot, 1'b0, '0);
            end
        end
    endtask

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            observed = '{m_status, m_granted_page, m_granted_slot, m_page_brought_in,
                         m_page_released, m_released_page};
            if (pending_results.size() == 0) begin
                note_mismatch({"unexpected transfer: ", result_text(observed)});
            end else begin
                wanted = pending_results.pop_front();
                if (observed.status !== wanted.status ||
                    observed.page !== wanted.page ||
                    observed.slot !== wanted.slot ||
                    observed.brought_in !== wanted.brought_in ||
                    observed.released !== wanted.released ||
                    observed.released_page !== wanted.released_page) begin
                    note_mismatch({"expected ", result_text(wanted), ", got ",
                                   result_text(observed)});
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < PAGE_COUNT; i++) begin
            slot_used[i] = '0;
            next_slot[i] = '0;
            page_live[i] = 1'b0;
        end
        next_page  = 0;
        spare_page = 0;

        sender_idle_pct   = 6;
        receiver_idle_pct = 66;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < OPENING_ROWS; i++) begin
            send_request(opening_rows[i].mode, opening_rows[i].page, opening_rows[i].slot,
                         opening_rows[i].known, opening_rows[i].result);
        end

        // Mostly allocations until the row of pages fills, then mostly frees so pages empty.
        random_requests(300, 90);
        sender_idle_pct   = 66;
        receiver_idle_pct = 6;
        random_requests(300, 90);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        random_requests(220, 20);
        s_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pbsa_pkg.sv
design/pbsa_ffz.sv
design/paged_bitmap_slot_allocator_top.sv
tb/sv/tb_top.sv
